// ===== sv/stt_pkg.sv =====
// Shared types and codes for the software timer slot table.
// Command and result codes, field widths and the token that walks the cell row.
// No dependencies.
`default_nettype none

package stt_pkg;

    localparam int SLOT_COUNT_DEF = 8;

    localparam int CMD_W    = 3;
    localparam int OWNER_W  = 16;
    localparam int IDX_W    = 8;
    localparam int PERIOD_W = 32;
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 3;

    localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNREGISTER = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PROCESS    = 3'd4;

    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [OWNER_W-1:0]  owner;
        logic [IDX_W-1:0]    idx;
        logic [PERIOD_W-1:0] period;
        logic                rep;
        logic                found;
        logic [SLOT_W-1:0]   slot;
        logic                run;
        logic                status;
    } tok_t;

    typedef struct packed {
        logic               fire;
        logic [OWNER_W-1:0] owner;
    } cell_fire_t;

endpackage

`default_nettype wire

// ===== sv/stt_if.sv =====
// Channel interfaces of the timer slot table: command in, result out.
// Depends on stt_pkg for field widths.
`default_nettype none

interface stt_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [stt_pkg::CMD_W-1:0]      cmd;
    logic [stt_pkg::OWNER_W-1:0]    owner_id;
    logic [stt_pkg::IDX_W-1:0]      slot_index;
    logic [stt_pkg::PERIOD_W-1:0]   period;
    logic                           repeat_req;

    modport source (output valid, cmd, owner_id, slot_index, period, repeat_req,
                    input ready);
    modport sink   (input valid, cmd, owner_id, slot_index, period, repeat_req,
                    output ready);
endinterface

interface stt_res_if;
    logic                           valid;
    logic                           ready;
    logic [stt_pkg::KIND_W-1:0]     result_kind;
    logic                           status;
    logic [stt_pkg::SLOT_W-1:0]     slot_out;
    logic [stt_pkg::OWNER_W-1:0]    owner_out;
    logic                           running;
    logic                           last;

    modport source (output valid, result_kind, status, slot_out, owner_out, running, last,
                    input ready);
    modport sink   (input valid, result_kind, status, slot_out, owner_out, running, last,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/software_timer_slot_table_core.sv =====
// Top level of the software timer slot table: entry register, row of slot cells
// and result register. Depends on stt_pkg, stt_if and stt_cell.
//
// Usage:
//   req carries one command per transfer (register, unregister, tick, query,
//   process). rsp carries the results: one acknowledgment for each command,
//   or for process one fire result per expired slot in slot order followed
//   by a done result; last marks the final result of a command.
//   A command enters an entry register, then its token walks the row of
//   SLOT_COUNT cells, one cell per cycle while the row moves, each cell acting on its own slot.
//   A cell that fires emits its result into the output register as the token
//   passes. The final result is loaded when the token leaves the last cell.
//   A new command is taken only once the token of the last one has left the
//   cell row; req.ready is low while a token is in flight.
//   When rsp.ready stays low while a result is held, the token keeps walking
//   until it reaches a firing cell or the row end, then holds there until the
//   output register is free.
//   Reset clears all slots (free, zero count), the row and the output valid flag.
`default_nettype none

module software_timer_slot_table_core #(
    parameter int SLOT_COUNT = stt_pkg::SLOT_COUNT_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    stt_cmd_if.sink     req,
    stt_res_if.source   rsp
);
    import stt_pkg::*;

    tok_t                     tok_chain [SLOT_COUNT+1];
    logic [SLOT_COUNT:0]      tv_chain;
    cell_fire_t               fire_vec [SLOT_COUNT];

    tok_t                     entry_reg;
    logic                     entry_valid_reg;
    tok_t                     entry_tok;

    logic                     out_valid_reg;
    logic [KIND_W-1:0]        kind_reg;
    logic                     status_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [OWNER_W-1:0]       owner_reg;
    logic                     running_reg;
    logic                     last_reg;

    logic                     accept;
    logic                     busy;
    logic                     out_free;
    logic                     fire_any;
    logic [SLOT_W-1:0]        fire_slot;
    logic [OWNER_W-1:0]       fire_owner;
    logic                     final_valid;
    tok_t                     final_tok;
    logic                     move;
    logic                     load;
    logic                     bad_idx;

    assign busy     = entry_valid_reg || (|tv_chain);
    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign tok_chain[0] = entry_reg;
    assign tv_chain[0]  = entry_valid_reg;

    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        stt_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .move          (move),
            .tok_valid     (tv_chain[i]),
            .tok           (tok_chain[i]),
            .tok_out_valid (tv_chain[i+1]),
            .tok_out       (tok_chain[i+1]),
            .fire_req      (fire_vec[i])
        );
    end

    always_comb
    begin
        fire_any   = 1'b0;
        fire_slot  = '0;
        fire_owner = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (fire_vec[i].fire)
            begin
                fire_any   = 1'b1;
                fire_slot  = SLOT_W'(i);
                fire_owner = fire_vec[i].owner;
            end
        end
    end

    assign final_valid = tv_chain[SLOT_COUNT];
    assign final_tok   = tok_chain[SLOT_COUNT];
    assign move        = out_free || !(fire_any || final_valid);
    assign load        = out_free && (fire_any || final_valid);

    assign bad_idx = req.slot_index >= IDX_W'(SLOT_COUNT);

    always_comb
    begin
        entry_tok        = '0;
        entry_tok.cmd    = req.cmd;
        entry_tok.owner  = req.owner_id;
        entry_tok.idx    = req.slot_index;
        entry_tok.period = req.period;
        entry_tok.rep    = req.repeat_req;
        case (req.cmd) inside
            CMD_REGISTER, CMD_TICK, CMD_PROCESS: entry_tok.status = 1'b0;
            CMD_UNREGISTER, CMD_QUERY:           entry_tok.status = bad_idx;
            default:                             entry_tok.status = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
                entry_valid_reg <= 1'b1;
            else if (move)
                entry_valid_reg <= 1'b0;
            if (load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            entry_reg <= entry_tok;
        if (load)
        begin
            if (fire_any)
            begin
                kind_reg    <= KIND_FIRE;
                status_reg  <= 1'b0;
                slot_reg    <= fire_slot;
                owner_reg   <= fire_owner;
                running_reg <= 1'b0;
                last_reg    <= 1'b0;
            end
            else
            begin
                kind_reg    <= (final_tok.cmd == CMD_PROCESS) ? KIND_DONE : KIND_ACK;
                owner_reg   <= '0;
                last_reg    <= 1'b1;
                running_reg <= (final_tok.cmd == CMD_QUERY) && !final_tok.status
                               && final_tok.run;
                if (final_tok.cmd == CMD_REGISTER)
                begin
                    status_reg <= !final_tok.found;
                    slot_reg   <= final_tok.found ? final_tok.slot : '0;
                end
                else
                begin
                    status_reg <= final_tok.status;
                    slot_reg   <= '0;
                end
            end
        end
    end

    assign req.ready       = !busy;
    assign rsp.valid       = out_valid_reg;
    assign rsp.result_kind = kind_reg;
    assign rsp.status      = status_reg;
    assign rsp.slot_out    = slot_reg;
    assign rsp.owner_out   = owner_reg;
    assign rsp.running     = running_reg;
    assign rsp.last        = last_reg;

endmodule

`default_nettype wire

// ===== sv/stt_cell.sv =====
// One timer slot: holds its state and acts on the command token passing by.
// Hands the token to the next cell on every move. Depends on stt_pkg.
`default_nettype none

module stt_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                move,
    input  wire logic                tok_valid,
    input  wire stt_pkg::tok_t       tok,
    output logic                     tok_out_valid,
    output stt_pkg::tok_t            tok_out,
    output stt_pkg::cell_fire_t      fire_req
);
    import stt_pkg::*;

    logic                valid_reg,  valid_next;
    logic [OWNER_W-1:0]  owner_reg,  owner_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [PERIOD_W-1:0] count_reg,  count_next;
    logic                repeat_reg, repeat_next;
    logic                tv_reg;
    tok_t                tok_reg,    tok_next;
    logic                fire;

    always_comb
    begin
        valid_next  = valid_reg;
        owner_next  = owner_reg;
        period_next = period_reg;
        count_next  = count_reg;
        repeat_next = repeat_reg;
        tok_next    = tok;
        fire        = 1'b0;
        if (tok_valid)
        begin
            case (tok.cmd)
                CMD_REGISTER:
                begin
                    if (!tok.found && (!valid_reg || owner_reg == tok.owner))
                    begin
                        valid_next     = 1'b1;
                        owner_next     = tok.owner;
                        period_next    = tok.period;
                        count_next     = '0;
                        repeat_next    = tok.rep;
                        tok_next.found = 1'b1;
                        tok_next.slot  = SLOT_W'(CELL_INDEX);
                    end
                end
                CMD_UNREGISTER:
                begin
                    if (tok.idx == IDX_W'(CELL_INDEX))
                        valid_next = 1'b0;
                end
                CMD_TICK:
                begin
                    if (valid_reg && count_reg != '1)
                        count_next = count_reg + PERIOD_W'(1);
                end
                CMD_QUERY:
                begin
                    if (tok.idx == IDX_W'(CELL_INDEX))
                        tok_next.run = valid_reg && (count_reg < period_reg);
                end
                CMD_PROCESS:
                begin
                    if (valid_reg && count_reg >= period_reg)
                    begin
                        fire = 1'b1;
                        if (repeat_reg)
                            count_next = '0;
                        else
                            valid_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            owner_reg  <= '0;
            period_reg <= '0;
            count_reg  <= '0;
            repeat_reg <= 1'b0;
            tv_reg     <= 1'b0;
        end
        else if (move)
        begin
            valid_reg  <= valid_next;
            owner_reg  <= owner_next;
            period_reg <= period_next;
            count_reg  <= count_next;
            repeat_reg <= repeat_next;
            tv_reg     <= tok_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
            tok_reg <= tok_next;
    end

    assign tok_out_valid  = tv_reg;
    assign tok_out        = tok_reg;
    assign fire_req.fire  = fire;
    assign fire_req.owner = owner_reg;

endmodule

`default_nettype wire

// ===== sv/stt_checker.sv =====
// Port-level checks for the software timer slot table, bound to the top level.
// Depends on stt_pkg and software_timer_slot_table_core.
`default_nettype none

module stt_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_valid,
    input wire logic                        req_ready,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic [stt_pkg::KIND_W-1:0]  rsp_result_kind,
    input wire logic                        rsp_status,
    input wire logic                        rsp_running,
    input wire logic                        rsp_last
);
    import stt_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("command taken while another is in flight");

    a_fire_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_result_kind == KIND_FIRE |-> !rsp_last && !rsp_status && !rsp_running)
        else $error("fire result with bad fields");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_result_kind == KIND_ACK || rsp_result_kind == KIND_DONE) |-> rsp_last)
        else $error("final result without last");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_result_kind != 2'd3)
        else $error("undefined result kind");

endmodule

bind software_timer_slot_table_core stt_checker u_stt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_result_kind (rsp.result_kind),
    .rsp_status      (rsp.status),
    .rsp_running     (rsp.running),
    .rsp_last        (rsp.last)
);

`default_nettype wire
